// File: design/shpd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash point de-duplication: shared package
// Field widths, register indexes, controller states and the command and
// status groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package shpd_pkg;

  // Fixed field widths.
  localparam int COORD_W  = 32;
  localparam int DIFF_W   = COORD_W + 1;
  localparam int INV_W    = 32;
  localparam int PROD_W   = COORD_W + INV_W;
  localparam int BINS_W   = 17;
  localparam int NODE_W   = 16;
  localparam int KEY_W    = 16;
  localparam int CNT_W    = 17;
  localparam int ENTRY_W  = NODE_W + 1;
  localparam int CFG_IDX_W = 3;

  // Clock edges from an accepted point to the edge that takes its result.
  localparam int ITEM_LATENCY = 9;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MIN_X        = 3'd0,
    REG_MIN_Y        = 3'd1,
    REG_MIN_Z        = 3'd2,
    REG_INV_BIN_SIZE = 3'd3,
    REG_BINS_X       = 3'd4,
    REG_BINS_Y       = 3'd5
  } cfg_reg_t;

  // Configuration register contents.
  typedef struct packed {
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] min_z;
    logic [INV_W-1:0]   inv_bin_size;
    logic [BINS_W-1:0]  bins_x;
    logic [BINS_W-1:0]  bins_y;
  } cfg_t;

  // Controller states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_MULT,
    ST_CLAMP,
    ST_TERM,
    ST_TERM2,
    ST_KEY,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_we;
    logic capture;
    logic diff_en;
    logic mult_en;
    logic clamp_en;
    logic term_en;
    logic term2_en;
    logic key_en;
    logic rd_en;
    logic upd_en;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
  } dp_stat_t;

endpackage

// File: design/shpd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash point de-duplication: controller
// Sequences the table clearing pass after reset and then steps each accepted
// point through the datapath stages, one stage per cycle.
// ----------------------------------------------------------------------------
module shpd_ctrl
  import shpd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat_i,
  output logic     busy,
  output dp_cmd_t  cmd_o
);

  state_t state_r;
  state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        cmd_o.clr_we = 1'b1;
        if (stat_i.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.capture = 1'b1;
          state_nxt     = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd_o.diff_en = 1'b1;
        state_nxt     = ST_MULT;
      end
      ST_MULT: begin
        cmd_o.mult_en = 1'b1;
        state_nxt     = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd_o.clamp_en = 1'b1;
        state_nxt      = ST_TERM;
      end
      ST_TERM: begin
        cmd_o.term_en = 1'b1;
        state_nxt     = ST_TERM2;
      end
      ST_TERM2: begin
        cmd_o.term2_en = 1'b1;
        state_nxt      = ST_KEY;
      end
      ST_KEY: begin
        cmd_o.key_en = 1'b1;
        state_nxt    = ST_READ;
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        state_nxt   = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.upd_en = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: design/shpd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash point de-duplication: datapath
// Per-axis quantisation lanes, saturating key linearisation, the node table
// with its read-modify-write port, the node counter and the result registers.
// ----------------------------------------------------------------------------
module shpd_datapath
  import shpd_pkg::*;
#(
  parameter int TABLE_DEPTH = 65536,
  parameter int FRAC_BITS   = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dp_cmd_t            cmd_i,
  output dp_stat_t           stat_o,
  input  cfg_t               cfg_i,
  input  logic [COORD_W-1:0] px_i,
  input  logic [COORD_W-1:0] py_i,
  input  logic [COORD_W-1:0] pz_i,
  output logic               out_valid_o,
  output logic [NODE_W-1:0]  node_id_o,
  output logic               is_new_o,
  output logic [KEY_W-1:0]   bin_key_o,
  output logic               overflow_o
);

  localparam int AW    = $clog2(TABLE_DEPTH);
  localparam int BIN_W = $clog2(TABLE_DEPTH + 1);
  localparam int TP_W  = BIN_W + BINS_W;
  localparam int SUM_W = BIN_W + 2;
  localparam int SHIFT = 2 * FRAC_BITS;

  // Lane registers (x, y, z).
  logic [COORD_W-1:0] coord_r [3];
  logic [COORD_W-1:0] dpos_r  [3];
  logic [COORD_W-1:0] dpos_nxt[3];
  logic [PROD_W-1:0]  prod_r  [3];
  logic [PROD_W-1:0]  prod_nxt[3];
  logic [BIN_W-1:0]   bin_r   [3];
  logic [BIN_W-1:0]   bin_nxt [3];
  logic [COORD_W-1:0] min_sel [3];

  // Key terms.
  logic [BIN_W-1:0] ty_r, ty_nxt, tzp_r, tzp_nxt, tz_r, tz_nxt;
  logic [KEY_W-1:0] tylo_r, tylo_nxt, tzplo_r, tzplo_nxt, tzlo_r, tzlo_nxt;
  logic [TP_W-1:0]  py_prod, pzp_prod, pz_prod;
  logic [SUM_W-1:0] key_sum;
  logic [AW-1:0]    addr_r;
  logic [KEY_W-1:0] keylo_r;
  logic             ovf_r;

  // Table and its control.
  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0] rd_r;
  logic [AW-1:0]      clr_addr_r;
  logic               we;
  logic [AW-1:0]      waddr;
  logic [ENTRY_W-1:0] wdata;
  logic               hit;
  logic               fresh;
  logic [CNT_W-1:0]   next_node_r;

  // Result registers.
  logic              out_valid_r;
  logic [NODE_W-1:0] node_r;
  logic              is_new_r;
  logic [KEY_W-1:0]  key_out_r;
  logic              ovf_out_r;

  assign min_sel[0] = cfg_i.min_x;
  assign min_sel[1] = cfg_i.min_y;
  assign min_sel[2] = cfg_i.min_z;

  // Offset from the box corner; a point at or below the corner lands in bin 0.
  always_comb begin
    logic [DIFF_W-1:0] d;
    for (int i = 0; i < 3; i++) begin
      d = {coord_r[i][COORD_W-1], coord_r[i]} - {min_sel[i][COORD_W-1], min_sel[i]};
      dpos_nxt[i] = (d[DIFF_W-1] || d == '0) ? '0 : d[COORD_W-1:0];
    end
  end

  // Scale by the reciprocal bin size, then floor and clamp to the table depth.
  always_comb begin
    logic [PROD_W-1:0] sh;
    for (int i = 0; i < 3; i++) begin
      prod_nxt[i] = PROD_W'(dpos_r[i]) * PROD_W'(cfg_i.inv_bin_size);
      sh          = prod_r[i] >> SHIFT;
      bin_nxt[i]  = (sh > PROD_W'(TABLE_DEPTH)) ? BIN_W'(TABLE_DEPTH) : sh[BIN_W-1:0];
    end
  end

  // Key terms saturate at the table depth: any saturated term already
  // overflows, so the sum stays exact wherever it matters.
  always_comb begin
    py_prod   = TP_W'(bin_r[1]) * TP_W'(cfg_i.bins_x);
    pzp_prod  = TP_W'(bin_r[2]) * TP_W'(cfg_i.bins_x);
    pz_prod   = TP_W'(tzp_r) * TP_W'(cfg_i.bins_y);
    ty_nxt    = (py_prod > TP_W'(TABLE_DEPTH)) ? BIN_W'(TABLE_DEPTH) : py_prod[BIN_W-1:0];
    tzp_nxt   = (pzp_prod > TP_W'(TABLE_DEPTH)) ? BIN_W'(TABLE_DEPTH) : pzp_prod[BIN_W-1:0];
    tz_nxt    = (pz_prod > TP_W'(TABLE_DEPTH)) ? BIN_W'(TABLE_DEPTH) : pz_prod[BIN_W-1:0];
    // The low key bits only need the low bits of every operand.
    tylo_nxt  = KEY_W'(bin_r[1]) * KEY_W'(cfg_i.bins_x);
    tzplo_nxt = KEY_W'(bin_r[2]) * KEY_W'(cfg_i.bins_x);
    tzlo_nxt  = tzplo_r * KEY_W'(cfg_i.bins_y);
    key_sum   = SUM_W'(bin_r[0]) + SUM_W'(ty_r) + SUM_W'(tz_r);
  end

  // Stage registers along the point's path.
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      coord_r[0] <= px_i;
      coord_r[1] <= py_i;
      coord_r[2] <= pz_i;
    end
    if (cmd_i.diff_en) begin
      dpos_r <= dpos_nxt;
    end
    if (cmd_i.mult_en) begin
      prod_r <= prod_nxt;
    end
    if (cmd_i.clamp_en) begin
      bin_r <= bin_nxt;
    end
    if (cmd_i.term_en) begin
      ty_r    <= ty_nxt;
      tzp_r   <= tzp_nxt;
      tylo_r  <= tylo_nxt;
      tzplo_r <= tzplo_nxt;
    end
    if (cmd_i.term2_en) begin
      tz_r   <= tz_nxt;
      tzlo_r <= tzlo_nxt;
    end
    if (cmd_i.key_en) begin
      ovf_r   <= (key_sum >= SUM_W'(TABLE_DEPTH));
      addr_r  <= key_sum[AW-1:0];
      keylo_r <= KEY_W'(bin_r[0]) + tylo_r + tzlo_r;
    end
  end

  // Table write port: clearing pass after reset, otherwise first-touch fill.
  assign hit   = rd_r[ENTRY_W-1];
  assign fresh = cmd_i.upd_en && !ovf_r && !hit;
  assign we    = cmd_i.clr_we || fresh;
  assign waddr = cmd_i.clr_we ? clr_addr_r : addr_r;
  assign wdata = cmd_i.clr_we ? '0 : {1'b1, next_node_r[NODE_W-1:0]};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Table read port with registered data.
  always_ff @(posedge clk) begin
    if (cmd_i.rd_en) begin
      rd_r <= mem[addr_r];
    end
  end

  // Clearing pass address and node counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      next_node_r <= '0;
    end else begin
      if (cmd_i.clr_we) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (fresh) begin
        next_node_r <= next_node_r + CNT_W'(1);
      end
    end
  end

  assign stat_o.clr_done = (clr_addr_r == AW'(TABLE_DEPTH - 1));

  // Result strobe.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd_i.upd_en;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd_i.upd_en) begin
      if (ovf_r) begin
        node_r <= '0;
      end else if (hit) begin
        node_r <= rd_r[NODE_W-1:0];
      end else begin
        node_r <= next_node_r[NODE_W-1:0];
      end
      is_new_r  <= !ovf_r && !hit;
      key_out_r <= keylo_r;
      ovf_out_r <= ovf_r;
    end
  end

  assign out_valid_o = out_valid_r;
  assign node_id_o   = node_r;
  assign is_new_o    = is_new_r;
  assign bin_key_o   = key_out_r;
  assign overflow_o  = ovf_out_r;

endmodule

// File: design/spatial_hash_point_dedup_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spatial hash point de-duplication unit
// Quantises each 3D point to a grid bin, linearises the bin to a key and
// returns the node id held for that key, handing out a fresh id on first use.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake              Payload
//  -------  ---------------------  ------------------------------------------
//  input    start / busy           in_px, in_py, in_pz
//  result   out_valid (strobe)     out_node_id, out_is_new, out_bin_key,
//                                  out_overflow
//  config   cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
//  A point is taken when start is high and busy is low; its result strobe is
//  taken at the edge ending it, which is also the first edge that can take a
//  new point. The controller's stage sequence is capture, offset, 32x32
//  scaling, clamp, two scaling multiplies of the key, key sum, table read and
//  write. After reset the table is cleared one entry per cycle, with busy
//  high; configuration writes are taken at any time. The receiver cannot
//  stall: the result strobe is high for a single cycle.
// ----------------------------------------------------------------------------
module spatial_hash_point_dedup_unit
  import shpd_pkg::*;
#(
  parameter int TABLE_DEPTH = 65536,
  parameter int FRAC_BITS   = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // Input channel
  input  logic                        start,
  output logic                        busy,
  input  logic signed [COORD_W-1:0]   in_px,
  input  logic signed [COORD_W-1:0]   in_py,
  input  logic signed [COORD_W-1:0]   in_pz,
  // Result channel
  output logic                        out_valid,
  output logic [NODE_W-1:0]           out_node_id,
  output logic                        out_is_new,
  output logic [KEY_W-1:0]            out_bin_key,
  output logic                        out_overflow,
  // Configuration channel
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [COORD_W-1:0]          cfg_wdata
);

  cfg_t     cfg_r;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_x        <= '0;
      cfg_r.min_y        <= '0;
      cfg_r.min_z        <= '0;
      cfg_r.inv_bin_size <= INV_W'(65536);
      cfg_r.bins_x       <= BINS_W'(1);
      cfg_r.bins_y       <= BINS_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MIN_X:        cfg_r.min_x        <= cfg_wdata;
        REG_MIN_Y:        cfg_r.min_y        <= cfg_wdata;
        REG_MIN_Z:        cfg_r.min_z        <= cfg_wdata;
        REG_INV_BIN_SIZE: cfg_r.inv_bin_size <= cfg_wdata;
        REG_BINS_X:       cfg_r.bins_x       <= cfg_wdata[BINS_W-1:0];
        REG_BINS_Y:       cfg_r.bins_y       <= cfg_wdata[BINS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Controller.
  shpd_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .stat_i (stat),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  // Datapath.
  shpd_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .cfg_i       (cfg_r),
    .px_i        (in_px),
    .py_i        (in_py),
    .pz_i        (in_pz),
    .out_valid_o (out_valid),
    .node_id_o   (out_node_id),
    .is_new_o    (out_is_new),
    .bin_key_o   (out_bin_key),
    .overflow_o  (out_overflow)
  );

  // An overflowed key stores nothing and reports a zero node id.
  a_ovf_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_node_id == '0 && !out_is_new)
    else $error("overflow result carries a node id or a fresh flag");

  // Every accepted point gets its result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |-> ##ITEM_LATENCY out_valid)
    else $error("result strobe missing after an accepted point");

  // One transaction in flight: strobes never come back to back.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two result strobes in consecutive cycles");

  // A result strobe only appears while the unit is ready again.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy || $past(start))
    else $error("result strobe while the sequencer is still busy");

endmodule
